### src/itdf2_pkg.sv
// ----------------------------------------------------------------------------
// itdf2_pkg
// Shared types and constants of the transposed direct form II biquad.
// ----------------------------------------------------------------------------
package itdf2_pkg;

   // Field widths
   localparam int SAMPLE_W  = 16;
   localparam int COEF_W    = 18;
   localparam int DELAY_W   = 40;
   localparam int ACC_W     = 41;   // b0*x + s0
   localparam int MUL_B_W   = 25;   // second multiplier operand
   localparam int PROD_W    = 43;   // COEF_W + MUL_B_W
   localparam int SUM_W     = 59;   // scale * acc
   localparam int TMP_W     = 42;   // delay term before saturation
   localparam int LO_BITS   = 24;   // low slice of acc for the split product
   localparam int Y_SHIFT   = 28;
   localparam int TERM_W    = 1;    // term index, covers filter orders 1 and 2

   // Register file
   localparam int NUM_REGS  = 6;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] REG_SCALE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FEED_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FEED_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FEED_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BACK_1 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BACK_2 = 3'd5;

   localparam logic signed [COEF_W-1:0] REG_RESET [NUM_REGS] = '{
      18'sd16384, 18'sd8192, 18'sd4096, 18'sd1638, 18'sd8192, 18'sd4915
   };

   localparam logic signed [PROD_W-1:0] ROUND_HALF = 43'sd134217728; // 2^27

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_LO,
      ST_HI,
      ST_Y,
      ST_TERM_A,
      ST_TERM_U,
      ST_HOLD
   } state_type;

   // What the datapath does with the registered product
   typedef enum logic [2:0] {
      OP_NONE,
      OP_ACC,
      OP_LO,
      OP_Y,
      OP_T,
      OP_UPD
   } op_type;

   // Second multiplier operand
   typedef enum logic [2:0] {
      B_X_IN,
      B_X,
      B_ACC_LO,
      B_ACC_HI,
      B_Y
   } bsel_type;

   typedef struct packed {
      logic                  load_x;
      op_type                op;
      bsel_type              b_sel;
      logic [CSR_IDX_W-1:0]  coef_sel;
      logic [TERM_W-1:0]     term;
      logic                  load_out;
   } cmd_type;

endpackage

### src/itdf2_req_if.sv
// ----------------------------------------------------------------------------
// itdf2_req_if
// Input sample channel.
// ----------------------------------------------------------------------------
interface itdf2_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [itdf2_pkg::SAMPLE_W-1:0]   sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

### src/itdf2_rsp_if.sv
// ----------------------------------------------------------------------------
// itdf2_rsp_if
// Filtered sample channel.
// ----------------------------------------------------------------------------
interface itdf2_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [itdf2_pkg::SAMPLE_W-1:0]   sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

### src/itdf2_csr_if.sv
// ----------------------------------------------------------------------------
// itdf2_csr_if
// Register write channel.
// ----------------------------------------------------------------------------
interface itdf2_csr_if;
   logic                                    valid;
   logic                                    ready;
   logic [itdf2_pkg::CSR_IDX_W-1:0]         index;
   logic [itdf2_pkg::COEF_W-1:0]            data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### src/itdf2_regs.sv
// ----------------------------------------------------------------------------
// itdf2_regs
// Coefficient and scale registers, written over the register channel.
// ----------------------------------------------------------------------------
module itdf2_regs (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  wr_valid,
   output logic                                  wr_ready,
   input  logic [itdf2_pkg::CSR_IDX_W-1:0]       wr_index,
   input  logic [itdf2_pkg::COEF_W-1:0]          wr_data,
   output logic signed [itdf2_pkg::COEF_W-1:0]   coef [itdf2_pkg::NUM_REGS]
);

   logic signed [itdf2_pkg::COEF_W-1:0] reg_ff [itdf2_pkg::NUM_REGS];

   assign wr_ready = 1'b1;

   // Write on every beat; drop indexes beyond the list
   always_ff @(posedge clock) begin
      if (reset) begin
         reg_ff <= itdf2_pkg::REG_RESET;
      end else if (wr_valid && wr_index < itdf2_pkg::CSR_IDX_W'(itdf2_pkg::NUM_REGS)) begin
         reg_ff[wr_index] <= wr_data;
      end
   end

   assign coef = reg_ff;

endmodule

### src/itdf2_ctrl.sv
// ----------------------------------------------------------------------------
// itdf2_ctrl
// Sequencer: steps the shared multiplier through one sample and owns the
// result valid flag.
// ----------------------------------------------------------------------------
module itdf2_ctrl #(
   parameter int ORDER = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output itdf2_pkg::cmd_type  cmd
);

   itdf2_pkg::state_type              state_ff, state_in;
   logic [itdf2_pkg::TERM_W-1:0]      term_ff, term_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              out_free;
   logic                              last_term;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_term = (term_ff == itdf2_pkg::TERM_W'(ORDER - 1));

   // State, term counter and result flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itdf2_pkg::ST_IDLE;
         term_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.op       = itdf2_pkg::OP_NONE;
      cmd.b_sel    = itdf2_pkg::B_X;
      cmd.coef_sel = itdf2_pkg::REG_SCALE;
      cmd.term     = term_ff;
      case (state_ff)
         itdf2_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.b_sel    = itdf2_pkg::B_X_IN;
            cmd.coef_sel = itdf2_pkg::REG_FEED_0;
            if (req_valid) begin
               cmd.load_x = 1'b1;
               state_in   = itdf2_pkg::ST_ACC;
            end
         end
         itdf2_pkg::ST_ACC: begin
            cmd.op   = itdf2_pkg::OP_ACC;
            state_in = itdf2_pkg::ST_LO;
         end
         itdf2_pkg::ST_LO: begin
            cmd.b_sel    = itdf2_pkg::B_ACC_LO;
            cmd.coef_sel = itdf2_pkg::REG_SCALE;
            state_in     = itdf2_pkg::ST_HI;
         end
         itdf2_pkg::ST_HI: begin
            cmd.op       = itdf2_pkg::OP_LO;
            cmd.b_sel    = itdf2_pkg::B_ACC_HI;
            cmd.coef_sel = itdf2_pkg::REG_SCALE;
            state_in     = itdf2_pkg::ST_Y;
         end
         itdf2_pkg::ST_Y: begin
            cmd.op       = itdf2_pkg::OP_Y;
            cmd.b_sel    = itdf2_pkg::B_X;
            cmd.coef_sel = itdf2_pkg::REG_FEED_1;
            term_in      = '0;
            state_in     = itdf2_pkg::ST_TERM_A;
         end
         itdf2_pkg::ST_TERM_A: begin
            cmd.op       = itdf2_pkg::OP_T;
            cmd.b_sel    = itdf2_pkg::B_Y;
            cmd.coef_sel = itdf2_pkg::REG_BACK_1 + itdf2_pkg::CSR_IDX_W'(term_ff);
            state_in     = itdf2_pkg::ST_TERM_U;
         end
         itdf2_pkg::ST_TERM_U: begin
            // issue the feed product of the following term
            cmd.op       = itdf2_pkg::OP_UPD;
            cmd.b_sel    = itdf2_pkg::B_X;
            cmd.coef_sel = itdf2_pkg::REG_FEED_1 + itdf2_pkg::CSR_IDX_W'(term_ff)
                           + itdf2_pkg::CSR_IDX_W'(1);
            if (!last_term) begin
               term_in  = term_ff + itdf2_pkg::TERM_W'(1);
               state_in = itdf2_pkg::ST_TERM_A;
            end else if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = itdf2_pkg::ST_IDLE;
            end else begin
               state_in = itdf2_pkg::ST_HOLD;
            end
         end
         itdf2_pkg::ST_HOLD: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = itdf2_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = itdf2_pkg::ST_IDLE;
         end
      endcase
   end

   // Raise on a new result, drop when the beat is taken
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == itdf2_pkg::ST_ACC)
      else $error("accepted sample did not start the sequence");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken beat");

   a_term_range: assert property (@(posedge clock) disable iff (reset)
      term_ff <= itdf2_pkg::TERM_W'(ORDER - 1))
      else $error("term index beyond filter order");

   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.load_out))
      else $error("result valid raised without a load");

endmodule

### src/itdf2_dpath.sv
// ----------------------------------------------------------------------------
// itdf2_dpath
// Datapath: shared 18x25 multiplier with registered product, accumulator,
// rounding and saturation, delay terms and result register.
// ----------------------------------------------------------------------------
module itdf2_dpath #(
   parameter int ORDER = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  itdf2_pkg::cmd_type                    cmd,
   input  logic signed [itdf2_pkg::SAMPLE_W-1:0] sample_in,
   input  logic signed [itdf2_pkg::COEF_W-1:0]   coef [itdf2_pkg::NUM_REGS],
   output logic signed [itdf2_pkg::SAMPLE_W-1:0] sample_out
);

   localparam int SW  = itdf2_pkg::SAMPLE_W;
   localparam int BW  = itdf2_pkg::MUL_B_W;
   localparam int AW  = itdf2_pkg::ACC_W;
   localparam int DW  = itdf2_pkg::DELAY_W;
   localparam int PW  = itdf2_pkg::PROD_W;
   localparam int SUW = itdf2_pkg::SUM_W;
   localparam int TW  = itdf2_pkg::TMP_W;
   localparam int LB  = itdf2_pkg::LO_BITS;
   localparam int YS  = itdf2_pkg::Y_SHIFT;
   localparam int HIW = SUW - LB;            // bits of scale * acc high slice

   logic signed [SW-1:0]  x_ff;
   logic signed [PW-1:0]  p_ff;
   logic signed [AW-1:0]  acc_ff;
   logic signed [PW-1:0]  lo_ff;
   logic signed [SW-1:0]  y_ff;
   logic signed [TW-1:0]  t_ff;
   logic signed [DW-1:0]  delay_ff [ORDER];
   logic signed [SW-1:0]  out_ff;

   logic signed [itdf2_pkg::COEF_W-1:0] mul_a;
   logic signed [BW-1:0]  mul_b;
   logic signed [PW-1:0]  mul_p;
   logic signed [DW-1:0]  delay_ext [ORDER+1];
   logic signed [DW-1:0]  next_term;
   logic [SUW-1:0]        sum_y;
   logic [SW-1:0]         y_sat;
   logic [TW-1:0]         upd_raw;
   logic [DW-1:0]         upd_sat;

   // Operand selection
   always_comb begin
      if (cmd.coef_sel < itdf2_pkg::CSR_IDX_W'(itdf2_pkg::NUM_REGS)) begin
         mul_a = coef[cmd.coef_sel];
      end else begin
         mul_a = '0;
      end
      case (cmd.b_sel)
         itdf2_pkg::B_X_IN:   mul_b = {{(BW-SW){sample_in[SW-1]}}, sample_in};
         itdf2_pkg::B_X:      mul_b = {{(BW-SW){x_ff[SW-1]}}, x_ff};
         itdf2_pkg::B_ACC_LO: mul_b = {{(BW-LB){1'b0}}, acc_ff[LB-1:0]};
         itdf2_pkg::B_ACC_HI: mul_b = {{(BW-(AW-LB)){acc_ff[AW-1]}}, acc_ff[AW-1:LB]};
         itdf2_pkg::B_Y:      mul_b = {{(BW-SW){y_ff[SW-1]}}, y_ff};
         default:             mul_b = '0;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Register the product every cycle
   always_ff @(posedge clock) begin
      p_ff <= mul_p;
   end

   // Pick the older delay term feeding term k; past the last one it is zero
   always_comb begin
      for (int i = 0; i < ORDER; i++) begin
         delay_ext[i] = delay_ff[i];
      end
      delay_ext[ORDER] = '0;
      next_term = '0;
      for (int i = 0; i < ORDER; i++) begin
         if (cmd.term == itdf2_pkg::TERM_W'(i)) begin
            next_term = delay_ext[i+1];
         end
      end
   end

   // Recombine the split scale product, round and saturate y
   always_comb begin
      sum_y = {p_ff[HIW-1:0], {LB{1'b0}}} + {{(SUW-PW){lo_ff[PW-1]}}, lo_ff};
      if (&sum_y[SUW-1:YS+SW-1] || ~|sum_y[SUW-1:YS+SW-1]) begin
         y_sat = sum_y[YS+SW-1:YS];
      end else if (sum_y[SUW-1]) begin
         y_sat = {1'b1, {(SW-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(SW-1){1'b1}}};
      end
   end

   // Delay term update with saturation to the delay width
   always_comb begin
      upd_raw = t_ff - p_ff[TW-1:0];
      if (&upd_raw[TW-1:DW-1] || ~|upd_raw[TW-1:DW-1]) begin
         upd_sat = upd_raw[DW-1:0];
      end else if (upd_raw[TW-1]) begin
         upd_sat = {1'b1, {(DW-1){1'b0}}};
      end else begin
         upd_sat = {1'b0, {(DW-1){1'b1}}};
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (cmd.load_x) begin
         x_ff <= sample_in;
      end
      case (cmd.op)
         itdf2_pkg::OP_ACC: acc_ff <= p_ff[AW-1:0] + {delay_ff[0][DW-1], delay_ff[0]};
         itdf2_pkg::OP_LO:  lo_ff  <= p_ff + itdf2_pkg::ROUND_HALF;
         itdf2_pkg::OP_Y:   y_ff   <= y_sat;
         itdf2_pkg::OP_T:   t_ff   <= {{(TW-DW){next_term[DW-1]}}, next_term} + p_ff[TW-1:0];
         default: begin
         end
      endcase
      if (cmd.load_out) begin
         out_ff <= y_ff;
      end
   end

   // Delay terms, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ORDER; i++) begin
            delay_ff[i] <= '0;
         end
      end else if (cmd.op == itdf2_pkg::OP_UPD) begin
         for (int i = 0; i < ORDER; i++) begin
            if (cmd.term == itdf2_pkg::TERM_W'(i)) begin
               delay_ff[i] <= upd_sat;
            end
         end
      end
   end

   assign sample_out = out_ff;

endmodule

### src/iir_transposed_df2_filter_unit.sv
// ----------------------------------------------------------------------------
// iir_transposed_df2_filter_unit
// Second-order IIR filter, transposed direct form II, Q1.15 in and out.
// ----------------------------------------------------------------------------
// One sample is accepted when the unit is idle and gives one filtered sample.
// All products go through a single 18x25 multiplier with a registered output,
// one at a time: one product for b0*x, two for the split scale*acc product,
// and a feed and a feedback product per delay term. The result sits in an
// output register, so the next sample is taken while the previous result
// waits to be read; the unit only stalls when a second result is done before
// the first is taken. Coefficients are to be written over the register
// channel while the unit is idle; the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module iir_transposed_df2_filter_unit #(
   parameter int ORDER = 2
) (
   input  logic              clock,
   input  logic              reset,
   itdf2_req_if.sink         req_bus,
   itdf2_rsp_if.source       rsp_bus,
   itdf2_csr_if.sink         csr_bus
);

   itdf2_pkg::cmd_type                   cmd;
   logic signed [itdf2_pkg::COEF_W-1:0]  coef [itdf2_pkg::NUM_REGS];

   // Coefficient registers
   itdf2_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_bus.valid),
      .wr_ready (csr_bus.ready),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .coef     (coef)
   );

   // Sequencer
   itdf2_ctrl #(
      .ORDER (ORDER)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   // Arithmetic
   itdf2_dpath #(
      .ORDER (ORDER)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sample_in  (req_bus.sample_in),
      .coef       (coef),
      .sample_out (rsp_bus.sample_out)
   );

endmodule
